// ===== rtl/lu8_pkg.sv =====
`timescale 1ns / 1ps

package lu8_pkg;

  localparam logic [7:0]  QMARK     = 8'h3F;
  localparam int          QDEPTH    = 2;
  localparam int          CP_W      = 21;
  localparam int          MAX_RES   = 3;

  // results caused by one accepted byte
  typedef struct packed {
    logic                          last;
    logic [1:0]                    cnt;
    logic [MAX_RES-1:0][CP_W-1:0]  cp;
  } bundle_t;

  // trailers a lead byte calls for, 0 if it opens no sequence
  function automatic logic [1:0] lead_trailers(input logic [7:0] c);
    logic [1:0] t;
    t = 2'd0;
    if ((c & 8'hE0) == 8'hC0)      t = 2'd1;
    else if ((c & 8'hF0) == 8'hE0) t = 2'd2;
    else if ((c & 8'hF8) == 8'hF0) t = 2'd3;
    return t;
  endfunction

  function automatic logic [CP_W-1:0] seq_value(input logic [7:0] lead,
                                                input logic [7:0] b1,
                                                input logic [7:0] b2,
                                                input logic [7:0] b3,
                                                input logic [1:0] t);
    logic [CP_W-1:0] v;
    unique case (t)
      2'd1:    v = {10'd0, lead[4:0], b1[5:0]};
      2'd2:    v = {5'd0, lead[3:0], b1[5:0], b2[5:0]};
      default: v = {lead[2:0], b1[5:0], b2[5:0], b3[5:0]};
    endcase
    return v;
  endfunction

  // decode a run of n bytes (1..4) as a text that ends there
  function automatic bundle_t decode_run(input logic [3:0][7:0] b,
                                         input logic [2:0] n);
    bundle_t          r;
    logic [7:0][7:0]  pb;
    logic [2:0]       i;
    logic [7:0]       c;
    logic [1:0]       t;
    r  = '0;
    pb = {32'h0, b};
    i  = 3'd0;
    for (int s = 0; s < MAX_RES; s++) begin
      if (i < n) begin
        c = pb[i];
        t = lead_trailers(c);
        r.cnt = r.cnt + 2'd1;
        if (c[7] == 1'b0) begin
          r.cp[s] = {13'd0, c};
          i = i + 3'd1;
        end else if (t != 2'd0 && ({1'b0, i} + {2'b00, t}) < {1'b0, n}) begin
          r.cp[s] = seq_value(c, pb[3'(i + 3'd1)], pb[3'(i + 3'd2)],
                              pb[3'(i + 3'd3)], t);
          i = i + 3'd1 + {1'b0, t};
        end else begin
          r.cp[s] = {13'd0, QMARK};
          i = i + 3'd1;
        end
      end
    end
    return r;
  endfunction

endpackage

// ===== rtl/lenient_utf8_decoder.sv =====
`timescale 1ns / 1ps
// lenient utf-8 decoder: bytes in, code points out
// input stream: in_tdata carries one text byte, in_tlast marks the last byte
// of a text; output stream: out_tdata carries a 21-bit code point, out_tlast
// marks the last code point of a text
// a lead byte opens a 2/3/4 byte sequence; trailers are taken unchecked,
// stray continuation bytes and F8-FF give '?', a text ending inside a
// sequence gives '?' for the lead and re-decodes the held trailers
// path: each code point is registered in the result queue and then in the
// output register before it shows on the output
// throughput: one byte per cycle while the queue has room; a byte that closes
// a truncated text can cause up to three code points, which leave at one per
// cycle from the back end while out_tready is high; meanwhile the two-entry
// queue can fill and in_tready drops until the back end frees an entry
// stall: when out_tready is low the output holds, the queue fills and
// in_tready drops once both entries are taken
// reset (rst_n low, synchronous): queue emptied, no sequence held, output
// invalid; no clearing pass is needed
module lenient_utf8_decoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tlast,   // end_of_text
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [20:0] code_point, [23:21] zero
  output logic        out_tlast   // final_result
);

  logic                     accept;
  logic                     push;
  lu8_pkg::bundle_t         front_bundle;
  logic                     q_full;
  logic                     head_valid;
  lu8_pkg::bundle_t         head;
  logic                     pop;
  logic [lu8_pkg::CP_W-1:0] cp;

  // front takes a byte whenever the queue has room
  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;

  // front: holds the open sequence and builds the results of each byte
  lu8_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .data_byte   (in_tdata),
    .end_of_text (in_tlast),
    .push        (push),
    .bundle      (front_bundle)
  );

  // queue of result groups between front and back
  lu8_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .wr_bundle  (front_bundle),
    .full       (q_full),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop)
  );

  // back: sends the code points of a group one per cycle while out_tready is high
  lu8_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_cp     (cp),
    .out_last   (out_tlast)
  );

  assign out_tdata = {3'b000, cp};

endmodule

// ===== rtl/lu8_front.sv =====
`timescale 1ns / 1ps

module lu8_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             accept,
  input  logic [7:0]       data_byte,
  input  logic             end_of_text,
  output logic             push,
  output lu8_pkg::bundle_t bundle
);

  logic [2:0][7:0] pend_r;
  logic [1:0]      pc_r, pc_nxt;
  logic [1:0]      need_r, need_nxt;
  logic            store;
  logic [3:0][7:0] run;
  logic [1:0]      tn;
  logic [1:0]      lt;

  always_comb begin
    run = '0;
    for (int j = 0; j < 3; j++) begin
      if (j < int'(pc_r)) run[j] = pend_r[j];
    end
    run[pc_r] = data_byte;
  end

  assign tn = (need_r == 2'd0) ? 2'd1 : need_r;
  assign lt = lu8_pkg::lead_trailers(data_byte);

  always_comb begin
    bundle   = '0;
    pc_nxt   = pc_r;
    need_nxt = need_r;
    store    = 1'b0;
    priority if (end_of_text) begin
      bundle      = lu8_pkg::decode_run(run, {1'b0, pc_r} + 3'd1);
      bundle.last = 1'b1;
      pc_nxt      = 2'd0;
      need_nxt    = 2'd0;
    end else if (pc_r == 2'd0) begin
      if (data_byte[7] == 1'b0) begin
        bundle.cnt   = 2'd1;
        bundle.cp[0] = {13'd0, data_byte};
      end else if (lt != 2'd0) begin
        store    = 1'b1;
        pc_nxt   = 2'd1;
        need_nxt = lt;
      end else begin
        bundle.cnt   = 2'd1;
        bundle.cp[0] = {13'd0, lu8_pkg::QMARK};
      end
    end else if (pc_r >= need_r) begin
      // sequence complete with this byte
      bundle.cnt   = 2'd1;
      bundle.cp[0] = lu8_pkg::seq_value(run[0], run[1], run[2], run[3], tn);
      pc_nxt       = 2'd0;
      need_nxt     = 2'd0;
    end else begin
      store  = 1'b1;
      pc_nxt = pc_r + 2'd1;
    end
  end

  assign push = accept && (bundle.cnt != 2'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r   <= 2'd0;
      need_r <= 2'd0;
    end else if (accept) begin
      pc_r   <= pc_nxt;
      need_r <= need_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && store) pend_r[pc_r] <= data_byte;
  end

endmodule

// ===== rtl/lu8_queue.sv =====
`timescale 1ns / 1ps

module lu8_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  lu8_pkg::bundle_t wr_bundle,
  output logic             full,
  output logic             head_valid,
  output lu8_pkg::bundle_t head,
  input  logic             pop
);

  localparam int AW = $clog2(lu8_pkg::QDEPTH);

  lu8_pkg::bundle_t mem_r [lu8_pkg::QDEPTH];
  logic [AW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [AW:0]      count_r, count_nxt;

  assign full       = (count_r == (AW+1)'(lu8_pkg::QDEPTH));
  assign head_valid = (count_r != '0);
  assign head       = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop)      count_nxt = count_r + (AW+1)'(1);
    else if (pop && !push) count_nxt = count_r - (AW+1)'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + AW'(1);
      if (pop)  rd_ptr_r <= rd_ptr_r + AW'(1);
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= wr_bundle;
  end

endmodule

// ===== rtl/lu8_back.sv =====
`timescale 1ns / 1ps

module lu8_back (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      head_valid,
  input  lu8_pkg::bundle_t          head,
  output logic                      pop,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [lu8_pkg::CP_W-1:0]  out_cp,
  output logic                      out_last
);

  logic [1:0]               sub_r;
  logic                     valid_r;
  logic [lu8_pkg::CP_W-1:0] cp_r;
  logic                     last_r;
  logic                     load;
  logic                     at_end;

  assign load   = head_valid && (!valid_r || out_ready);
  assign at_end = (sub_r == head.cnt - 2'd1);
  assign pop    = load && at_end;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sub_r   <= 2'd0;
      valid_r <= 1'b0;
    end else begin
      if (load) begin
        sub_r   <= at_end ? 2'd0 : sub_r + 2'd1;
        valid_r <= 1'b1;
      end else if (out_ready) begin
        valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cp_r   <= head.cp[sub_r];
      last_r <= head.last && at_end;
    end
  end

  assign out_valid = valid_r;
  assign out_cp    = cp_r;
  assign out_last  = last_r;

endmodule

// ===== rtl/lu8_checker.sv =====
`timescale 1ns / 1ps

module lu8_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata,
  input logic        out_tlast
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("output changed while stalled");

  // padding bits above the code point stay zero
  a_pad_zero: assert property (@(posedge clk)
    out_tvalid |-> out_tdata[23:21] == 3'b000)
    else $error("nonzero padding in out_tdata");

  // reset leaves no result pending
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid right after reset");

  // input stays open while the output stays idle
  a_ready_flow: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid && $past(!out_tvalid) && $past(rst_n) |-> in_tready)
    else $error("input blocked with an idle output");

endmodule

bind lenient_utf8_decoder lu8_checker u_lu8_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

// ===== tb/sv/tb_lenient_utf8_decoder.sv =====
`timescale 1ns / 1ps

module tb_lenient_utf8_decoder;

  localparam int CYCLE_LIMIT = 200000;
  localparam int SETTLE = 12;        // leave some slack after the last owed code point
  localparam int RANDOM_BYTES = 330;
  localparam int QUIET_FROM = 120;   // no random idling on either side in this item window
  localparam int QUIET_TO = 260;

  // one text byte waiting to go out, optionally holding until all code points are back
  typedef struct {
    logic [7:0] data;
    logic fin;
    logic drain;
  } text_byte_t;

  // one code point the decoder owes us
  typedef struct {
    logic [lu8_pkg::CP_W-1:0] cp;
    logic fin;
  } code_point_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [7:0] in_tdata = 8'h00;   // [7:0] data_byte
  logic in_tlast = 1'b0;          // end_of_text
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [23:0] out_tdata;         // [20:0] code_point, [23:21] zero
  logic out_tlast;                // final_result

  text_byte_t bytes_to_send[$];
  code_point_t code_points_due[$];
  code_point_t oldest_due;

  // decoder state as we track it
  logic [7:0] held_bytes[3];
  int unsigned held_cnt = 0;
  int unsigned want_cnt = 0;

  int unsigned cycles = 0;
  int unsigned bytes_taken = 0;
  int unsigned texts_taken = 0;
  int unsigned code_points_seen = 0;
  int unsigned truncated_texts = 0;
  int unsigned errors = 0;

  lenient_utf8_decoder dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  always #10 clk = ~clk;

  // number of trailers a lead byte opens, 0 for anything else
  function automatic int unsigned trailers_of(input logic [7:0] c);
    if (c[7:5] == 3'b110) return 1;
    if (c[7:4] == 4'b1110) return 2;
    if (c[7:3] == 5'b11110) return 3;
    return 0;
  endfunction

  // join lead at position s with its t trailers, payload bits only
  function automatic logic [lu8_pkg::CP_W-1:0] assemble(input logic [3:0][7:0] run,
                                                        input int unsigned s,
                                                        input int unsigned t);
    logic [lu8_pkg::CP_W-1:0] v;
    if (t == 1) v = lu8_pkg::CP_W'(run[s][4:0]);
    else if (t == 2) v = lu8_pkg::CP_W'(run[s][3:0]);
    else v = lu8_pkg::CP_W'(run[s][2:0]);
    for (int j = 1; j <= int'(t); j++)
      v = (v << 6) | lu8_pkg::CP_W'(run[s + j][5:0]);
    return v;
  endfunction

  // advance the tracked decoder by one byte and queue the code points it causes
  task automatic decode_byte(input logic [7:0] c, input logic fin);
    logic [3:0][7:0] run;
    logic [lu8_pkg::CP_W-1:0] cps[3];
    code_point_t due;
    int unsigned n;
    int unsigned i;
    int unsigned t;
    int unsigned k;
    run = '0;
    k = 0;
    for (int j = 0; j < int'(held_cnt); j++) run[j] = held_bytes[j];
    run[held_cnt] = c;
    n = held_cnt + 1;
    if (fin) begin
      // text ends here: whatever is held plus this byte is decoded as a text of its own
      if (held_cnt != 0) truncated_texts++;
      i = 0;
      while (i < n && k < 3) begin
        t = trailers_of(run[i]);
        if (!run[i][7]) begin
          cps[k] = lu8_pkg::CP_W'(run[i]);
          i = i + 1;
        end else if (t != 0 && i + t < n) begin
          cps[k] = assemble(run, i, t);
          i = i + 1 + t;
        end else begin
          // stray byte, or a lead that runs past the end
          cps[k] = lu8_pkg::CP_W'(lu8_pkg::QMARK);
          i = i + 1;
        end
        k++;
      end
      held_cnt = 0;
      want_cnt = 0;
    end else if (held_cnt == 0) begin
      t = trailers_of(c);
      if (!c[7]) begin
        cps[k] = lu8_pkg::CP_W'(c);
        k++;
      end else if (t != 0) begin
        held_bytes[0] = c;
        held_cnt = 1;
        want_cnt = t;
      end else begin
        cps[k] = lu8_pkg::CP_W'(lu8_pkg::QMARK);
        k++;
      end
    end else if (n >= want_cnt + 1) begin
      // any byte counts as a trailer, its form is never looked at
      cps[k] = assemble(run, 0, want_cnt);
      k++;
      held_cnt = 0;
      want_cnt = 0;
    end else begin
      held_bytes[held_cnt] = c;
      held_cnt = n;
    end
    for (int j = 0; j < int'(k); j++) begin
      due.cp = cps[j];
      due.fin = fin && (j == int'(k) - 1);
      code_points_due.insert(code_points_due.size(), due);
    end
  endtask

  task automatic report_mismatch(input string what);
    errors++;
    $display("[%0t] mismatch: %s", $realtime, what);
  endtask

  function automatic logic quiet_window();
    return bytes_taken >= QUIET_FROM && bytes_taken < QUIET_TO;
  endfunction

  // input driver: predicts on each accepted item, then offers the next one
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        decode_byte(in_tdata, in_tlast);
        bytes_taken++;
        if (in_tlast) texts_taken++;
      end
      if (!in_tvalid || in_tready) begin
        if (bytes_to_send.size() == 0) begin
          in_tvalid <= 1'b0;
        end else if (bytes_to_send[0].drain && (in_tvalid || code_points_due.size() != 0)) begin
          // hold off until every owed code point has come back
          in_tvalid <= 1'b0;
        end else if (!quiet_window() && $urandom_range(99) < 6) begin
          in_tvalid <= 1'b0;
        end else begin
          in_tdata <= bytes_to_send[0].data;
          in_tlast <= bytes_to_send[0].fin;
          in_tvalid <= 1'b1;
          void'(bytes_to_send.pop_front());
        end
      end
    end
  end

  // output side: random back pressure
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= quiet_window() || ($urandom_range(99) >= 6);
    end
  end

  // monitor: every accepted code point against the oldest one owed
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      code_points_seen++;
      if (code_points_due.size() == 0) begin
        report_mismatch($sformatf("code point %h with none owed", out_tdata));
      end else begin
        oldest_due = code_points_due.pop_front();
        if (out_tdata !== {3'b000, oldest_due.cp})
          report_mismatch($sformatf("code point %h, wanted %h", out_tdata, oldest_due.cp));
        if (out_tlast !== oldest_due.fin)
          report_mismatch($sformatf("last flag %b on %h, wanted %b",
                                    out_tlast, out_tdata, oldest_due.fin));
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d code points still owed",
               cycles, code_points_due.size());
      $display("** lenient_utf8_decoder: FAILED **");
      $finish;
    end
  end

  task automatic queue_text(input logic [7:0] b[$], input logic drain_first);
    foreach (b[j])
      bytes_to_send.insert(bytes_to_send.size(),
                           text_byte_t'{data: b[j], fin: (j == b.size() - 1),
                                        drain: drain_first && (j == 0)});
  endtask

  // random lead byte of a 2, 3 or 4 byte sequence
  function automatic logic [7:0] random_lead(input int unsigned t);
    if (t == 1) return 8'hC0 | 8'($urandom_range(31));
    if (t == 2) return 8'hE0 | 8'($urandom_range(15));
    return 8'hF0 | 8'($urandom_range(7));
  endfunction

  initial begin
    logic [7:0] txt[$];
    int unsigned random_sent;
    int unsigned roll;
    int unsigned t;

    // directed texts
    txt = '{8'h00, 8'h7F, 8'h80, 8'hBF, 8'hF8, 8'hFF};          // ascii ends, stray bytes
    queue_text(txt, 1'b0);
    txt = '{8'hC3, 8'hA9, 8'hE2, 8'h82, 8'hAC, 8'hF0, 8'h9F, 8'h98, 8'h80};
    queue_text(txt, 1'b0);                                       // 2, 3 and 4 byte forms
    txt = '{8'hED, 8'hA0, 8'h80, 8'hC0, 8'h80, 8'h41};           // surrogate and overlong pass
    queue_text(txt, 1'b0);
    txt = '{8'hE0, 8'h41, 8'hC2, 8'hC2};                         // unchecked trailers, lead at end
    queue_text(txt, 1'b0);
    txt = '{8'hF4, 8'h80, 8'hC3};                                // truncated, three '?'
    queue_text(txt, 1'b0);
    txt = '{8'hF0, 8'hC3, 8'hA9};                                // truncated, tail re-decoded
    queue_text(txt, 1'b0);
    txt = '{8'hFF};                                              // stray byte ending a text
    queue_text(txt, 1'b0);

    // random texts: mostly well formed characters, some noise and broken sequences
    random_sent = 0;
    while (random_sent < RANDOM_BYTES) begin
      txt = {};
      repeat ($urandom_range(1, 6)) begin
        roll = $urandom_range(99);
        if (roll < 30) begin
          txt.insert(txt.size(), 8'($urandom_range(127)));
        end else if (roll < 80) begin
          t = (roll < 50) ? 1 : (roll < 65) ? 2 : 3;
          txt.insert(txt.size(), random_lead(t));
          repeat (t) txt.insert(txt.size(), 8'h80 | 8'($urandom_range(63)));
        end else if (roll < 90) begin
          txt.insert(txt.size(), 8'($urandom_range(255)));
        end else begin
          // lead with too few trailers, the next character fills in
          t = $urandom_range(1, 3);
          txt.insert(txt.size(), random_lead(t));
          repeat ($urandom_range(t - 1))
            txt.insert(txt.size(), 8'h80 | 8'($urandom_range(63)));
        end
      end
      if ($urandom_range(4) == 0) begin
        // text cut off inside a sequence
        t = $urandom_range(1, 3);
        txt.insert(txt.size(), random_lead(t));
        repeat ($urandom_range(t - 1)) txt.insert(txt.size(), 8'($urandom_range(255)));
      end
      // pause for a full drain at the start and about halfway through
      queue_text(txt, random_sent == 0 || (random_sent < RANDOM_BYTES / 2 &&
                      random_sent + txt.size() >= RANDOM_BYTES / 2));
      random_sent += txt.size();
    end

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    while (bytes_to_send.size() != 0 || in_tvalid || code_points_due.size() != 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);

    $display("run covered %0d bytes in %0d texts, %0d of them cut off inside a sequence",
             bytes_taken, texts_taken, truncated_texts);
    $display("%0d code points checked, %0d mismatches", code_points_seen, errors);
    if (errors == 0) begin
      $display("** lenient_utf8_decoder: PASSED **");
    end else begin
      $display("** lenient_utf8_decoder: FAILED **");
    end
    $finish;
  end

endmodule

// ===== lenient_utf8_decoder.f =====
rtl/lu8_pkg.sv
rtl/lu8_front.sv
rtl/lu8_queue.sv
rtl/lu8_back.sv
rtl/lenient_utf8_decoder.sv
rtl/lu8_checker.sv
tb/sv/tb_lenient_utf8_decoder.sv
